// ===== rtl/exsort_pkg.sv =====
// exsort_pkg: shared constants and command types for the exchange sort unit
// no dependencies; imported by exsort_ctrl, exsort_dp, exsort_chk and the top level
`default_nettype none

package exsort_pkg;

    // record store depth and derived widths
    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // record field widths
    localparam int KEY_W = 16;
    localparam int TAG_W = 3;

    // source of the data written into the record store
    typedef enum logic
    {
        WR_INPUT,
        WR_HELD
    } wr_src_t;

    // commands from the controller to the datapath
    typedef struct packed
    {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        wr_src_t          wr_src;
        logic [IDX_W-1:0] rd_addr;
        logic             hold_ld;
        logic             out_ld;
    } exsort_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/exsort_dp.sv =====
// exsort_dp: record store, held record register, compare and output registers
// depends on exsort_pkg
`default_nettype none

module exsort_dp
(
    input  wire logic                                clk,
    input  wire exsort_pkg::exsort_cmd_t             cmd,
    input  wire logic signed [exsort_pkg::KEY_W-1:0] sort_key,
    input  wire logic        [exsort_pkg::TAG_W-1:0] record_tag,
    output logic                                     rd_less,
    output logic signed      [exsort_pkg::KEY_W-1:0] out_key,
    output logic             [exsort_pkg::TAG_W-1:0] out_tag
);
    import exsort_pkg::*;

    // record store, one write and one registered read per cycle
    logic        [KEY_W-1:0] key_mem [DEPTH];
    logic        [TAG_W-1:0] tag_mem [DEPTH];

    logic signed [KEY_W-1:0] rd_key_reg;
    logic        [TAG_W-1:0] rd_tag_reg;
    logic signed [KEY_W-1:0] held_key_reg;
    logic        [TAG_W-1:0] held_tag_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic        [TAG_W-1:0] out_tag_reg;

    logic        [KEY_W-1:0] wr_key;
    logic        [TAG_W-1:0] wr_tag;

    // write data select: incoming item or the held record
    always_comb
    begin
        case (cmd.wr_src)
            WR_INPUT:
            begin
                wr_key = sort_key;
                wr_tag = record_tag;
            end
            WR_HELD:
            begin
                wr_key = held_key_reg;
                wr_tag = held_tag_reg;
            end
            default:
            begin
                wr_key = sort_key;
                wr_tag = record_tag;
            end
        endcase
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[cmd.wr_addr] <= wr_key;
            tag_mem[cmd.wr_addr] <= wr_tag;
        end
        rd_key_reg <= key_mem[cmd.rd_addr];
        rd_tag_reg <= tag_mem[cmd.rd_addr];
    end

    // held record at position i, swapped with smaller keys
    always_ff @(posedge clk)
    begin
        if (cmd.hold_ld)
        begin
            held_key_reg <= rd_key_reg;
            held_tag_reg <= rd_tag_reg;
        end
    end

    // output record register
    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_key_reg <= rd_key_reg;
            out_tag_reg <= rd_tag_reg;
        end
    end

    // key j strictly below the held key
    assign rd_less = (rd_key_reg < held_key_reg);
    assign out_key = out_key_reg;
    assign out_tag = out_tag_reg;

endmodule

`default_nettype wire

// ===== rtl/exsort_ctrl.sv =====
// exsort_ctrl: load, sort and emit sequencer with fill count and index counters
// depends on exsort_pkg
`default_nettype none

module exsort_ctrl
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    last_item,
    input  wire logic                    out_ready,
    input  wire logic                    rd_less,
    output exsort_pkg::exsort_cmd_t      cmd,
    output logic                         in_ready,
    output logic                         out_valid,
    output logic                         out_last,
    output logic                         overflow
);
    import exsort_pkg::*;

    typedef enum logic [3:0]
    {
        S_LOAD,
        S_IRD,
        S_IHOLD,
        S_JRD,
        S_JCMP,
        S_IWB,
        S_ORD,
        S_OLD,
        S_OWAIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             dropped_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_reg;
    logic             out_valid_reg;
    logic             out_last_reg;
    logic             overflow_reg;

    logic             in_acc;
    logic             room;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] n_m1;
    logic [CNT_W-1:0] n_m2;

    // load bookkeeping
    assign in_acc    = in_valid && (state_reg == S_LOAD);
    assign room      = (fill_reg < CNT_W'(DEPTH));
    assign fill_next = room ? (fill_reg + CNT_W'(1)) : fill_reg;
    assign n_m1      = fill_reg - CNT_W'(1);
    assign n_m2      = fill_reg - CNT_W'(2);

    // datapath commands decoded from state
    always_comb
    begin
        cmd         = '0;
        cmd.wr_src  = WR_INPUT;
        cmd.wr_addr = fill_reg[IDX_W-1:0];
        cmd.rd_addr = i_reg[IDX_W-1:0];
        case (state_reg)
            S_LOAD:
            begin
                cmd.wr_en = in_acc && room;
            end
            S_IRD:
            begin
                cmd.rd_addr = i_reg[IDX_W-1:0];
            end
            S_IHOLD:
            begin
                cmd.hold_ld = 1'b1;
            end
            S_JRD:
            begin
                cmd.rd_addr = j_reg[IDX_W-1:0];
            end
            S_JCMP:
            begin
                cmd.wr_en   = rd_less;
                cmd.wr_addr = j_reg[IDX_W-1:0];
                cmd.wr_src  = WR_HELD;
                cmd.hold_ld = rd_less;
            end
            S_IWB:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = i_reg[IDX_W-1:0];
                cmd.wr_src  = WR_HELD;
            end
            S_ORD:
            begin
                cmd.rd_addr = k_reg[IDX_W-1:0];
            end
            S_OLD:
            begin
                cmd.out_ld = 1'b1;
            end
            default:
            begin
                cmd.wr_en = 1'b0;
            end
        endcase
    end

    // state, counters and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        fill_reg <= fill_next;
                        if (!room)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (last_item)
                        begin
                            i_reg <= '0;
                            k_reg <= '0;
                            if (fill_next >= CNT_W'(2))
                            begin
                                state_reg <= S_IRD;
                            end
                            else
                            begin
                                state_reg <= S_ORD;
                            end
                        end
                    end
                end
                S_IRD:
                begin
                    state_reg <= S_IHOLD;
                end
                S_IHOLD:
                begin
                    j_reg     <= i_reg + CNT_W'(1);
                    state_reg <= S_JRD;
                end
                S_JRD:
                begin
                    state_reg <= S_JCMP;
                end
                S_JCMP:
                begin
                    if (j_reg == n_m1)
                    begin
                        state_reg <= S_IWB;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= S_JRD;
                    end
                end
                S_IWB:
                begin
                    if (i_reg == n_m2)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_ORD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_IRD;
                    end
                end
                S_ORD:
                begin
                    state_reg <= S_OLD;
                end
                S_OLD:
                begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= (k_reg == n_m1);
                    overflow_reg  <= dropped_reg;
                    state_reg     <= S_OWAIT;
                end
                S_OWAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            fill_reg    <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CNT_W'(1);
                            state_reg <= S_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire

// ===== rtl/exchange_sort_ascending_keys_unit.sv =====
// load takes items while in_ready; after the last of a set of n records, each
// outer step i reads and holds record i, compares it with each record j > i,
// swapping on a smaller key, then writes it back; each record is then read and
// held until out_ready; one set at a time, paced by the single store read port
// reset: async active low clears the sequencer, fill count and drop flag;
// store contents stay undefined until written
// top level: joins exsort_ctrl and exsort_dp; depends on exsort_pkg
`default_nettype none

module exchange_sort_ascending_keys_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [exsort_pkg::KEY_W-1:0] sort_key,
    input  wire logic        [exsort_pkg::TAG_W-1:0] record_tag,
    input  wire logic                                last_item,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [exsort_pkg::KEY_W-1:0] out_key,
    output logic             [exsort_pkg::TAG_W-1:0] out_tag,
    output logic                                     out_last,
    output logic                                     overflow
);
    import exsort_pkg::*;

    exsort_cmd_t cmd;
    logic        rd_less;

    // sequencer
    exsort_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_item (last_item),
        .out_ready (out_ready),
        .rd_less   (rd_less),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_last  (out_last),
        .overflow  (overflow)
    );

    // record store and compare
    exsort_dp u_dp
    (
        .clk        (clk),
        .cmd        (cmd),
        .sort_key   (sort_key),
        .record_tag (record_tag),
        .rd_less    (rd_less),
        .out_key    (out_key),
        .out_tag    (out_tag)
    );

endmodule

`default_nettype wire

// ===== rtl/exsort_chk.sv =====
// exsort_chk: port-level checks on the exchange sort unit, bound to the top level
// depends on exsort_pkg
`default_nettype none

module exsort_chk
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic                                last_item,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic signed [exsort_pkg::KEY_W-1:0] out_key,
    input  wire logic                                out_last
);
    import exsort_pkg::*;

    // a pending item holds its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before the item was taken");

    // a pending item holds its key
    a_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_key))
        else $error("out_key changed while stalled");

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input open while a result is pending");

    // a last item closes the input side
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_item |=> !in_ready)
        else $error("input still open after a last item");

    // the final result of a run is followed by a gap
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("result shown right after the end of a run");

endmodule

bind exchange_sort_ascending_keys_unit exsort_chk u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_item (last_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_key   (out_key),
    .out_last  (out_last)
);

`default_nettype wire
